>>> hdl/pgaa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgaa_pkg
// Shared constants and types for the polar Gaussian AWGN adder datapath.
// ----------------------------------------------------------------------------
package pgaa_pkg;

    localparam int SIGMA_W       = 16;
    localparam int LOG_FRAC_BITS = 24;
    localparam int NORM_STEPS    = 6;
    localparam int ISQ_STEPS     = 32;
    localparam int DIV_STEPS     = 31;
    localparam int ROOT_W        = 32;

    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_NOISE = 1'b1;

    typedef logic [SIGMA_W-1:0] t_sigma;
    typedef logic [ROOT_W-1:0]  t_root;

    localparam t_sigma SIGMA_RESET = 16'd4096;

endpackage
`default_nettype wire

>>> hdl/polar_gaussian_awgn_adder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polar_gaussian_awgn_adder
// Polar-method complex Gaussian noise generator with sigma scaling,
// optional addition to a data sample and output saturation.
// ----------------------------------------------------------------------------
// A request passes through the front end (squares, reject, normalization),
// the 32-stage root, the 31-stage divide and 3 output stages.
// Throughput: one request per cycle unless held; rejected pairs leave a bubble.
// A skid entry behind the result register takes one waiting result; the input
// is held while the skid is full. Synchronous active-low reset clears valid bits
// and sets sigma to 1.0; no clearing pass.
// ----------------------------------------------------------------------------
module polar_gaussian_awgn_adder #(
    parameter int UNIFORM_BITS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_command,
    input  wire logic signed [UNIFORM_BITS-1:0] i_uniform_a,
    input  wire logic signed [UNIFORM_BITS-1:0] i_uniform_b,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_data_real,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_data_imag,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pgaa_pkg::SIGMA_W-1:0]   i_noise_sigma,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_out_real,
    output logic signed [SAMPLE_BITS-1:0]       o_out_imag,
    output logic                                o_clipped
);
    import pgaa_pkg::*;

    localparam int UB     = UNIFORM_BITS;
    localparam int UF     = UNIFORM_BITS - 1;
    localparam int SB     = SAMPLE_BITS;
    localparam int SW     = 2 * UNIFORM_BITS;
    localparam int ST_M   = 3 + NORM_STEPS;
    localparam int ST_G   = ST_M + LOG_FRAC_BITS + 2 + ISQ_STEPS;
    localparam int ST_R   = ST_M + ISQ_STEPS;
    localparam int ST_C   = ST_R + DIV_STEPS;
    localparam int G_DLY  = ST_C - ST_G;
    localparam int LAST   = ST_C + 3;
    localparam int PAY_W  = 3 + 2 * SAMPLE_BITS;
    localparam int SUM_W  = ((SAMPLE_BITS > 22) ? SAMPLE_BITS : 22) + 2;

    localparam logic [SW-1:0] S_LIM = SW'(1) << (2 * UF);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic   en;
    logic   r_vld [0:LAST];
    t_sigma r_sigma;

    // ---------------- handshake and skid ----------------
    logic                 r_sk_vld;
    logic [SB-1:0]        r_sk_re, r_sk_im;
    logic                 r_sk_clip;
    logic [SB-1:0]        r_ore, r_oim;
    logic                 r_oclip;

    assign en          = !r_sk_vld;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_sk_vld | r_vld[LAST];
    assign o_out_real  = r_sk_vld ? r_sk_re : r_ore;
    assign o_out_imag  = r_sk_vld ? r_sk_im : r_oim;
    assign o_clipped   = r_sk_vld ? r_sk_clip : r_oclip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (i_ready) r_sk_vld <= 1'b0;
        end else if (r_vld[LAST] && !i_ready) begin
            r_sk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld && r_vld[LAST] && !i_ready) begin
            r_sk_re   <= r_ore;
            r_sk_im   <= r_oim;
            r_sk_clip <= r_oclip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= SIGMA_RESET;
        end else if (i_cfg_valid) begin
            r_sigma <= i_noise_sigma;
        end
    end

    // ---------------- stage 0..2: squares and reject ----------------
    logic                 r_cmd0;
    logic signed [UB-1:0] r_ua0, r_ub0;
    logic [SB-1:0]        r_dr0, r_di0;
    logic [UB-1:0]        r_ma1, r_mb1, r_ma2, r_mb2;
    logic [SW-1:0]        r_sqa1, r_sqb1, r_s2;
    logic [SW-1:0]        n_s;
    logic                 n_ok;

    assign n_s  = r_sqa1 + r_sqb1;
    assign n_ok = (n_s != '0) && (n_s < S_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LAST; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1] && n_ok;
            for (int i = 3; i <= LAST; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd0 <= i_command;
            r_ua0  <= i_uniform_a;
            r_ub0  <= i_uniform_b;
            r_dr0  <= i_data_real;
            r_di0  <= i_data_imag;
            r_ma1  <= r_ua0[UB-1] ? UB'(-r_ua0) : UB'(r_ua0);
            r_mb1  <= r_ub0[UB-1] ? UB'(-r_ub0) : UB'(r_ub0);
            r_sqa1 <= SW'(r_ua0[UB-1] ? UB'(-r_ua0) : UB'(r_ua0))
                    * SW'(r_ua0[UB-1] ? UB'(-r_ua0) : UB'(r_ua0));
            r_sqb1 <= SW'(r_ub0[UB-1] ? UB'(-r_ub0) : UB'(r_ub0))
                    * SW'(r_ub0[UB-1] ? UB'(-r_ub0) : UB'(r_ub0));
            r_s2   <= n_s;
            r_ma2  <= r_ma1;
            r_mb2  <= r_mb1;
        end
    end

    logic [PAY_W-1:0] w_pay;
    pgaa_delay #(.W(PAY_W), .DEPTH(LAST - 1)) u_dly_pay (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_cmd0, r_ua0[UB-1], r_ub0[UB-1], r_dr0, r_di0}),
        .o_data (w_pay)
    );

    // ---------------- normalization ----------------
    logic [63:0] r_nx [0:NORM_STEPS-1];
    logic [63:0] r_ns [0:NORM_STEPS-1];
    logic [5:0]  r_nz [0:NORM_STEPS-1];

    for (genvar gj = 0; gj < NORM_STEPS; gj++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - gj);
        logic [63:0] w_x, w_s;
        logic [5:0]  w_z;
        if (gj == 0) begin : g_first
            assign w_x = 64'(r_s2);
            assign w_s = 64'(r_s2);
            assign w_z = '0;
        end else begin : g_next
            assign w_x = r_nx[gj-1];
            assign w_s = r_ns[gj-1];
            assign w_z = r_nz[gj-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ns[gj] <= w_s;
                if (w_x[63 -: SH] == '0) begin
                    r_nx[gj] <= w_x << SH;
                    r_nz[gj] <= w_z | 6'(SH);
                end else begin
                    r_nx[gj] <= w_x;
                    r_nz[gj] <= w_z;
                end
            end
        end
    end

    logic [2*UB-1:0] w_mag8;
    pgaa_delay #(.W(2 * UB), .DEPTH(NORM_STEPS)) u_dly_mag (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_ma2, r_mb2}),
        .o_data (w_mag8)
    );

    logic [5:0]  n_e;
    logic [6:0]  n_kd;
    logic [4:0]  n_k;
    logic [30:0] r_m9;
    logic [5:0]  r_e9;
    logic [63:0] r_v9;
    logic [30:0] r_mk9 [0:1];

    assign n_e  = 6'd63 - r_nz[NORM_STEPS-1];
    assign n_kd = 7'd61 - 7'(n_e);
    assign n_k  = (n_e >= 6'd60) ? 5'd0 : n_kd[5:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m9     <= r_nx[NORM_STEPS-1][63:33];
            r_e9     <= n_e;
            r_v9     <= r_ns[NORM_STEPS-1] << {n_k, 1'b0};
            r_mk9[0] <= 31'(64'(w_mag8[2*UB-1:UB]) << n_k);
            r_mk9[1] <= 31'(64'(w_mag8[UB-1:0]) << n_k);
        end
    end

    // ---------------- log2 by repeated squaring ----------------
    logic [30:0]              r_lm [0:LOG_FRAC_BITS-1];
    logic [LOG_FRAC_BITS-1:0] r_lf [0:LOG_FRAC_BITS-1];
    logic [5:0]               r_le [0:LOG_FRAC_BITS-1];

    for (genvar gl = 0; gl < LOG_FRAC_BITS; gl++) begin : g_log
        logic [30:0]              w_m;
        logic [LOG_FRAC_BITS-1:0] w_f;
        logic [5:0]               w_e;
        logic [61:0]              w_sq;
        if (gl == 0) begin : g_first
            assign w_m = r_m9;
            assign w_f = '0;
            assign w_e = r_e9;
        end else begin : g_next
            assign w_m = r_lm[gl-1];
            assign w_f = r_lf[gl-1];
            assign w_e = r_le[gl-1];
        end
        assign w_sq = 62'(w_m) * 62'(w_m);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_le[gl] <= w_e;
                if (w_sq[61]) begin
                    r_lm[gl] <= w_sq[61:31];
                    r_lf[gl] <= {w_f[LOG_FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_lm[gl] <= w_sq[60:30];
                    r_lf[gl] <= {w_f[LOG_FRAC_BITS-2:0], 1'b0};
                end
            end
        end
    end

    logic [29:0] r_t;
    logic [34:0] r_l;
    logic [60:0] w_tl;

    assign w_tl = 61'(r_t) * 61'(TWO_LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t <= {6'(2 * UF) - r_le[LOG_FRAC_BITS-1], 24'd0}
                 - 30'(r_lf[LOG_FRAC_BITS-1]);
            r_l <= w_tl[60:26];
        end
    end

    t_root w_g_raw, w_g, w_r;

    pgaa_isqrt u_isq_g (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value ({1'b0, r_l, 28'd0}),
        .o_root  (w_g_raw)
    );

    pgaa_delay #(.W(ROOT_W), .DEPTH(G_DLY)) u_dly_g (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (w_g_raw),
        .o_data (w_g)
    );

    // ---------------- 1/sqrt(W) by root and divide ----------------
    pgaa_isqrt u_isq_r (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r_v9),
        .o_root  (w_r)
    );

    logic [61:0] w_mk41;
    pgaa_delay #(.W(62), .DEPTH(ISQ_STEPS)) u_dly_mk (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({r_mk9[0], r_mk9[1]}),
        .o_data (w_mk41)
    );

    logic [60:0] r_dd [0:DIV_STEPS-1][0:1];
    logic [30:0] r_dq [0:DIV_STEPS-1][0:1];
    logic [30:0] r_dv [0:DIV_STEPS-1];

    for (genvar gd = 0; gd < DIV_STEPS; gd++) begin : g_div
        logic [30:0] w_dv;
        if (gd == 0) begin : g_first
            assign w_dv = w_r[30:0];
        end else begin : g_next
            assign w_dv = r_dv[gd-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) r_dv[gd] <= w_dv;
        end
        for (genvar gn = 0; gn < 2; gn++) begin : g_lane
            logic [60:0] w_d;
            logic [30:0] w_q;
            logic [61:0] w_sub;
            if (gd == 0) begin : g_first
                assign w_d = {w_mk41[61 - 31*gn -: 31], 30'd0};
                assign w_q = '0;
            end else begin : g_next
                assign w_d = r_dd[gd-1][gn];
                assign w_q = r_dq[gd-1][gn];
            end
            assign w_sub = 62'(w_dv) << (DIV_STEPS - 1 - gd);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (62'(w_d) >= w_sub) begin
                        r_dd[gd][gn] <= 61'(62'(w_d) - w_sub);
                        r_dq[gd][gn] <= w_q | (31'd1 << (DIV_STEPS - 1 - gd));
                    end else begin
                        r_dd[gd][gn] <= w_d;
                        r_dq[gd][gn] <= w_q;
                    end
                end
            end
        end
    end

    // ---------------- scale, round, add, saturate ----------------
    logic [32:0] r_x [0:1];
    logic [21:0] r_n [0:1];
    logic [62:0] w_cg [0:1];
    logic [49:0] w_xs [0:1];

    for (genvar gn = 0; gn < 2; gn++) begin : g_scale
        assign w_cg[gn] = 63'(r_dq[DIV_STEPS-1][gn]) * 63'(w_g);
        assign w_xs[gn] = 50'(r_x[gn]) * 50'(r_sigma) + (50'd1 << 27);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[gn] <= w_cg[gn][62:30];
                r_n[gn] <= w_xs[gn][49:28];
            end
        end
    end

    logic                    w_cmd, w_sa, w_sb;
    logic [SB-1:0]           w_pdr, w_pdi;
    logic signed [SUM_W-1:0] w_dre, w_dim, w_nre, w_nim, w_sre, w_sim;
    logic                    w_hre, w_lre, w_him, w_lim;

    assign {w_cmd, w_sa, w_sb, w_pdr, w_pdi} = w_pay;
    assign w_dre = (w_cmd == CMD_NOISE) ? '0 : SUM_W'($signed(w_pdr));
    assign w_dim = (w_cmd == CMD_NOISE) ? '0 : SUM_W'($signed(w_pdi));
    assign w_nre = w_sa ? -$signed(SUM_W'(r_n[0])) : $signed(SUM_W'(r_n[0]));
    assign w_nim = w_sb ? -$signed(SUM_W'(r_n[1])) : $signed(SUM_W'(r_n[1]));
    assign w_sre = w_dre + w_nre;
    assign w_sim = w_dim + w_nim;
    assign w_hre = w_sre > SAT_HI;
    assign w_lre = w_sre < SAT_LO;
    assign w_him = w_sim > SAT_HI;
    assign w_lim = w_sim < SAT_LO;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ore   <= w_hre ? SAT_HI[SB-1:0] : (w_lre ? SAT_LO[SB-1:0] : w_sre[SB-1:0]);
            r_oim   <= w_him ? SAT_HI[SB-1:0] : (w_lim ? SAT_LO[SB-1:0] : w_sim[SB-1:0]);
            r_oclip <= w_hre | w_lre | w_him | w_lim;
        end
    end

    // ---------------- assertions ----------------
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s2 != '0 && r_s2 < S_LIM))
        else $error("rejected pair kept valid");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_R] |-> (w_r[31:30] == 2'b01))
        else $error("normalized root out of range");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_C] |-> (r_dq[DIV_STEPS-1][0] <= (31'd1 << 30)
                         && r_dq[DIV_STEPS-1][1] <= (31'd1 << 30)))
        else $error("normalized uniform exceeds one");

    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_vld && !i_ready) |=> (r_sk_vld && $stable(r_sk_re) && $stable(r_sk_im)))
        else $error("skid entry lost");

endmodule
`default_nettype wire

>>> hdl/pgaa_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgaa_delay
// Stallable delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module pgaa_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_dly [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_data = r_dly[DEPTH-1];

endmodule
`default_nettype wire

>>> hdl/pgaa_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgaa_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module pgaa_isqrt (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [63:0]    i_value,
    output pgaa_pkg::t_root     o_root
);
    import pgaa_pkg::*;

    logic [63:0] r_rem  [0:ISQ_STEPS-1];
    logic [63:0] r_root [0:ISQ_STEPS-1];

    for (genvar gi = 0; gi < ISQ_STEPS; gi++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
        logic [63:0] w_rem;
        logic [63:0] w_root;
        logic [63:0] w_cand;

        if (gi == 0) begin : g_first
            assign w_rem  = i_value;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[gi-1];
            assign w_root = r_root[gi-1];
        end

        assign w_cand = w_root + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_rem >= w_cand) begin
                    r_rem[gi]  <= w_rem - w_cand;
                    r_root[gi] <= (w_root >> 1) + BIT;
                end else begin
                    r_rem[gi]  <= w_rem;
                    r_root[gi] <= w_root >> 1;
                end
            end
        end
    end

    assign o_root = r_root[ISQ_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire
